// ----- sv/aspt_pkg.sv -----
// ----------------------------------------------------------------------------
// aspt_pkg
// Shared widths, codes and controller/datapath handshake types for the
// session phase tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package aspt_pkg;

  localparam int MAX_SESSIONS = 16;
  localparam int PTR_W        = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;

  localparam int CMD_W   = 4;
  localparam int IDX_W   = 4;
  localparam int WORD_W  = 32;
  localparam int KIND_W  = 3;
  localparam int PHASE_W = 3;
  localparam int EXP_W   = 5;

  localparam logic [CMD_W-1:0] CMD_ADD         = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CONNECT     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DISCONNECT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CONN_ACK    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_ALIVE       = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DISCONN_ACK = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FIN         = 4'd6;
  localparam logic [CMD_W-1:0] CMD_INFO        = 4'd7;
  localparam logic [CMD_W-1:0] CMD_ERROR       = 4'd8;

  localparam logic [KIND_W-1:0] PKT_NONE          = 3'd0;
  localparam logic [KIND_W-1:0] PKT_CONN_REQ      = 3'd1;
  localparam logic [KIND_W-1:0] PKT_CONN_RSP      = 3'd2;
  localparam logic [KIND_W-1:0] PKT_KEEPALIVE_RSP = 3'd3;
  localparam logic [KIND_W-1:0] PKT_CLOSE_REQ     = 3'd4;
  localparam logic [KIND_W-1:0] PKT_CLOSE_RSP     = 3'd5;

  localparam logic [PHASE_W-1:0] PH_IDLE          = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CONNECTING    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CONNECTED     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DISCONNECTING = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DISCONNECTED  = 3'd5;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic ptr_inc;
    logic tick_step;
    logic exec;
    logic push;
  } aspt_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic in_search;
    logic hit;
    logic last;
    logic out_free;
  } aspt_stat_t;

  typedef struct packed {
    logic               accepted;
    logic [KIND_W-1:0]  send_kind;
    logic [WORD_W-1:0]  send_control;
    logic [IDX_W-1:0]   result_session;
    logic [PHASE_W-1:0] new_phase;
    logic               wrong_phase;
    logic               control_mismatch;
    logic [EXP_W-1:0]   expired_count;
  } aspt_res_t;

endpackage

`default_nettype wire

// ----- sv/aspt_in_if.sv -----
// ----------------------------------------------------------------------------
// aspt_in_if
// Command word channel into the session phase tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface aspt_in_if import aspt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic               is_tick;
  logic [IDX_W-1:0]   session_index;
  logic [WORD_W-1:0]  peer_address;
  logic [WORD_W-1:0]  control_value;
  logic [WORD_W-1:0]  session_timeout;
  logic [WORD_W-1:0]  keepalive_timeout;
  logic               connect_now;

  modport source (
    output valid, command, is_tick, session_index, peer_address, control_value,
           session_timeout, keepalive_timeout, connect_now,
    input  ready
  );

  modport sink (
    input  valid, command, is_tick, session_index, peer_address, control_value,
           session_timeout, keepalive_timeout, connect_now,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/aspt_out_if.sv -----
// ----------------------------------------------------------------------------
// aspt_out_if
// Result word channel out of the session phase tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface aspt_out_if import aspt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [KIND_W-1:0]  send_kind;
  logic [WORD_W-1:0]  send_control;
  logic [IDX_W-1:0]   result_session;
  logic [PHASE_W-1:0] new_phase;
  logic               wrong_phase;
  logic               control_mismatch;
  logic [EXP_W-1:0]   expired_count;

  modport source (
    output valid, accepted, send_kind, send_control, result_session, new_phase,
           wrong_phase, control_mismatch, expired_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, send_kind, send_control, result_session, new_phase,
           wrong_phase, control_mismatch, expired_count,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/aspt_ctrl.sv -----
// ----------------------------------------------------------------------------
// aspt_ctrl
// Sequencer: takes a word, walks the session table for ticks and lookups,
// fires the update and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aspt_ctrl import aspt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire aspt_stat_t stat,
  output aspt_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SEARCH,
    ST_EXEC,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_tick) begin
            state_nxt = ST_TICK;
          end else if (stat.in_search) begin
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (stat.hit) begin
          state_nxt = ST_EXEC;
        end else if (stat.last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/aspt_dp.sv -----
// ----------------------------------------------------------------------------
// aspt_dp
// Session table, time counter, walk pointer, update logic and output
// register of the session phase tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module aspt_dp import aspt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aspt_in_if.sink    in_ch,
  aspt_out_if.source out_ch,
  input  wire aspt_cmd_t cmd,
  output aspt_stat_t stat
);

  // latched command word
  logic [CMD_W-1:0]  cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WORD_W-1:0] addr_r;
  logic [WORD_W-1:0] cv_r;
  logic [WORD_W-1:0] sto_r;
  logic [WORD_W-1:0] kto_r;
  logic              cnow_r;

  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [WORD_W-1:0] sec_r, sec_nxt;
  logic [MAX_SESSIONS-1:0] used_r;

  logic [WORD_W-1:0]  addr_mem  [MAX_SESSIONS];
  logic [PHASE_W-1:0] phase_mem [MAX_SESSIONS];
  logic [WORD_W-1:0]  ctl_mem   [MAX_SESSIONS];
  logic [WORD_W-1:0]  sto_mem   [MAX_SESSIONS];
  logic [WORD_W-1:0]  kto_mem   [MAX_SESSIONS];
  logic [WORD_W-1:0]  ptime_mem [MAX_SESSIONS];

  aspt_res_t res_r, res_nxt;
  aspt_res_t out_r;
  logic      out_valid_r;

  // table write controls
  logic               used_we;
  logic               addr_we;
  logic               to_we;
  logic [WORD_W-1:0]  sto_wd;
  logic [WORD_W-1:0]  kto_wd;
  logic               ctl_we;
  logic [WORD_W-1:0]  ctl_wd;
  logic               ph_we;
  logic [PHASE_W-1:0] ph_wd;

  logic               ent_used;
  logic [PHASE_W-1:0] ent_ph;
  logic [WORD_W-1:0]  ent_ctl;
  logic [WORD_W-1:0]  elapsed;
  logic [WORD_W-1:0]  cv_inc;
  logic               rep_ok;
  logic               in_reply;

  assign ent_used = used_r[ptr_r];
  assign ent_ph   = phase_mem[ptr_r];
  assign ent_ctl  = ctl_mem[ptr_r];
  assign elapsed  = sec_r - ptime_mem[ptr_r];
  assign cv_inc   = cv_r + WORD_W'(1);
  assign rep_ok   = (32'(idx_r) < 32'(MAX_SESSIONS)) && ent_used;
  assign in_reply = !(in_ch.command inside {CMD_ADD, CMD_CONNECT, CMD_DISCONNECT});

  // status toward the sequencer
  always_comb begin
    stat.in_valid  = in_ch.valid;
    stat.in_tick   = in_ch.is_tick;
    stat.in_search = !in_reply;
    stat.last      = (ptr_r == PTR_W'(MAX_SESSIONS - 1));
    stat.out_free  = !out_valid_r || out_ch.ready;
    if (cmd_r == CMD_ADD) begin
      stat.hit = !ent_used;
    end else begin
      stat.hit = ent_used && (addr_mem[ptr_r] == addr_r);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    sec_nxt = sec_r;
    res_nxt = res_r;
    used_we = 1'b0;
    addr_we = 1'b0;
    to_we   = 1'b0;
    sto_wd  = sto_r;
    kto_wd  = kto_r;
    ctl_we  = 1'b0;
    ctl_wd  = cv_inc;
    ph_we   = 1'b0;
    ph_wd   = PH_IDLE;

    if (cmd.load) begin
      ptr_nxt = (!in_ch.is_tick && in_reply) ? PTR_W'(in_ch.session_index) : '0;
      if (in_ch.is_tick) begin
        sec_nxt = sec_r + WORD_W'(1);
      end
      res_nxt           = '0;
      res_nxt.new_phase = PH_IDLE;
      res_nxt.accepted  = in_ch.is_tick;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + PTR_W'(1);
    end

    if (cmd.tick_step) begin
      if (ent_used && (((ent_ph == PH_CONNECTED) && (elapsed > sto_mem[ptr_r])) ||
                       ((ent_ph == PH_CONNECTING) && (elapsed > kto_mem[ptr_r])))) begin
        ph_we = 1'b1;
        ph_wd = PH_IDLE;
        res_nxt.expired_count = res_r.expired_count + EXP_W'(1);
      end
    end

    if (cmd.exec) begin
      case (cmd_r)
        CMD_ADD: begin
          used_we = 1'b1;
          addr_we = 1'b1;
          to_we   = 1'b1;
          sto_wd  = '0;
          kto_wd  = '0;
          ctl_we  = 1'b1;
          ctl_wd  = '0;
          ph_we   = 1'b1;
          ph_wd   = cnow_r ? PH_CONNECTING : PH_IDLE;
          res_nxt.accepted       = 1'b1;
          res_nxt.send_kind      = cnow_r ? PKT_CONN_REQ : PKT_NONE;
          res_nxt.result_session = IDX_W'(ptr_r);
          res_nxt.new_phase      = ph_wd;
        end
        CMD_CONNECT: begin
          ph_we = 1'b1;
          ph_wd = PH_CONNECTING;
          res_nxt.accepted       = 1'b1;
          res_nxt.send_kind      = PKT_CONN_REQ;
          res_nxt.result_session = IDX_W'(ptr_r);
          res_nxt.new_phase      = PH_CONNECTING;
          res_nxt.wrong_phase    = !(ent_ph inside {PH_IDLE, PH_DISCONNECTED});
        end
        CMD_DISCONNECT: begin
          ph_we = 1'b1;
          ph_wd = PH_DISCONNECTING;
          res_nxt.accepted       = 1'b1;
          res_nxt.send_kind      = PKT_CLOSE_REQ;
          res_nxt.result_session = IDX_W'(ptr_r);
          res_nxt.new_phase      = PH_DISCONNECTING;
          res_nxt.wrong_phase    = (ent_ph != PH_CONNECTED);
        end
        default: begin
          if (rep_ok && (cmd_r <= CMD_ERROR)) begin
            res_nxt.result_session = IDX_W'(ptr_r);
            res_nxt.new_phase      = ent_ph;
            case (cmd_r)
              CMD_CONN_ACK: begin
                if (ent_ph != PH_CONNECTING) begin
                  res_nxt.wrong_phase = 1'b1;
                end else begin
                  ph_we  = 1'b1;
                  ph_wd  = PH_CONNECTED;
                  to_we  = 1'b1;
                  ctl_we = 1'b1;
                  res_nxt.send_kind    = PKT_CONN_RSP;
                  res_nxt.send_control = cv_inc;
                end
              end
              CMD_ALIVE: begin
                if (ent_ph != PH_CONNECTED) begin
                  res_nxt.wrong_phase = 1'b1;
                end else begin
                  ph_we  = 1'b1;
                  ph_wd  = PH_CONNECTED;
                  ctl_we = 1'b1;
                  res_nxt.send_kind    = PKT_KEEPALIVE_RSP;
                  res_nxt.send_control = cv_inc;
                end
              end
              CMD_DISCONN_ACK: begin
                if (ent_ph != PH_DISCONNECTING) begin
                  res_nxt.wrong_phase = 1'b1;
                end else begin
                  ph_we  = 1'b1;
                  ph_wd  = PH_DISCONNECTED;
                  ctl_we = 1'b1;
                  res_nxt.send_kind        = PKT_CLOSE_RSP;
                  res_nxt.send_control     = cv_inc;
                  res_nxt.control_mismatch = (ent_ctl + WORD_W'(1)) != cv_r;
                end
              end
              CMD_FIN: begin
                if (ent_ph != PH_DISCONNECTED) begin
                  res_nxt.wrong_phase = 1'b1;
                end else begin
                  ph_we = 1'b1;
                  ph_wd = PH_IDLE;
                end
              end
              CMD_INFO: begin
              end
              default: begin
                ph_we = 1'b1;
                ph_wd = PH_IDLE;
              end
            endcase
            res_nxt.accepted = !res_nxt.wrong_phase;
            if (ph_we) begin
              res_nxt.new_phase = ph_wd;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sec_r <= sec_nxt;
      if (used_we) begin
        used_r[ptr_r] <= 1'b1;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    res_r <= res_nxt;
    if (cmd.push) begin
      out_r <= res_r;
    end
    if (cmd.load) begin
      cmd_r  <= in_ch.command;
      idx_r  <= in_ch.session_index;
      addr_r <= in_ch.peer_address;
      cv_r   <= in_ch.control_value;
      sto_r  <= in_ch.session_timeout;
      kto_r  <= in_ch.keepalive_timeout;
      cnow_r <= in_ch.connect_now;
    end
  end

  // session table write port
  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[ptr_r] <= addr_r;
    end
    if (to_we) begin
      sto_mem[ptr_r] <= sto_wd;
      kto_mem[ptr_r] <= kto_wd;
    end
    if (ctl_we) begin
      ctl_mem[ptr_r] <= ctl_wd;
    end
    if (ph_we) begin
      phase_mem[ptr_r] <= ph_wd;
      ptime_mem[ptr_r] <= sec_r;
    end
  end

  assign in_ch.ready             = cmd.in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.accepted         = out_r.accepted;
  assign out_ch.send_kind        = out_r.send_kind;
  assign out_ch.send_control     = out_r.send_control;
  assign out_ch.result_session   = out_r.result_session;
  assign out_ch.new_phase        = out_r.new_phase;
  assign out_ch.wrong_phase      = out_r.wrong_phase;
  assign out_ch.control_mismatch = out_r.control_mismatch;
  assign out_ch.expired_count    = out_r.expired_count;

endmodule

`default_nettype wire

// ----- sv/auth_session_phase_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// auth_session_phase_tracker_unit
// Client login session table with phase tracking and timeout expiry.
//
// in_ch carries one command word: a tick, an add, a connect or disconnect
// by peer address, or a received reply for a session index. out_ch returns
// exactly one result word per command word, in order.
// Steps from the accepting edge to out_ch.valid, with MAX_SESSIONS = N:
//   reply, info, error, unknown code : update, then done and output push
//   tick                             : walk all N entries, one table entry a cycle
//   add, connect, disconnect         : walk the entries until the match, then
//                                      update, done and push (no update with no match)
// One word is in work at a time; the table has a single shared port.
// in_ch.ready is high only while the sequencer is idle. The result sits in
// an output register, so the next word is taken while out_ch is stalled;
// its own result waits in res_r in the datapath until the register frees.
// Reset clears the session-used bits, the second counter and out_ch.valid;
// the rest of the table is written by add before any read.
// ----------------------------------------------------------------------------
`default_nettype none

module auth_session_phase_tracker_unit import aspt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aspt_in_if.sink    in_ch,
  aspt_out_if.source out_ch
);

  aspt_cmd_t  cmd;
  aspt_stat_t stat;

  aspt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  aspt_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

`default_nettype wire

// ----- sv/aspt_checker.sv -----
// ----------------------------------------------------------------------------
// aspt_checker
// Port-level checks on the result channel of the session phase tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module aspt_checker import aspt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_accepted,
  input wire logic [KIND_W-1:0]  out_send_kind,
  input wire logic [PHASE_W-1:0] out_new_phase,
  input wire logic               out_control_mismatch,
  input wire logic [EXP_W-1:0]   out_expired_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_kind))
    else $error("result word changed while stalled");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_send_kind == PKT_NONE)
    else $error("packet sent for a rejected command");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_new_phase >= PH_IDLE && out_new_phase <= PH_DISCONNECTED)
    else $error("phase out of range");

  a_expire_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired_count != '0 |-> out_accepted && out_send_kind == PKT_NONE)
    else $error("expiry reported on a non-tick word");

  a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_control_mismatch |-> out_send_kind == PKT_CLOSE_RSP)
    else $error("control mismatch without disconnect ack");

endmodule

bind auth_session_phase_tracker_unit aspt_checker u_aspt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_accepted         (out_ch.accepted),
  .out_send_kind        (out_ch.send_kind),
  .out_new_phase        (out_ch.new_phase),
  .out_control_mismatch (out_ch.control_mismatch),
  .out_expired_count    (out_ch.expired_count)
);

`default_nettype wire
